// File: src/gsrr_pkg.sv
// Package with the shared types, widths and codes of the shift-reduce recogniser.
`timescale 1ns / 1ps
`default_nettype none
package gsrr_pkg;

    localparam int STACK_DEPTH_DEF = 8;
    localparam int NUM_RULES_DEF   = 8;
    localparam int MAX_RHS_DEF     = 6;
    localparam int MAX_REDUCE_DEF  = 16;

    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_W     = 4;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 4;
    localparam int RULE_W      = 64;
    localparam int RHS_LSB     = 16;
    localparam int NUM_REGS    = 8;

    typedef logic [SYM_W-1:0]       t_symbol;
    typedef logic [RULE_W-1:0]      t_rule;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING  = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_REJECT   = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_LIMIT    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_REDUCE = 2'd1,
        S_DONE   = 2'd2
    } t_state;

    function automatic int clamp_idx(input int k, input int hi);
        return (k < hi) ? k : hi;
    endfunction

endpackage
`default_nettype wire

// File: src/gsrr_in_if.sv
// Interface of the input symbol channel.
`timescale 1ns / 1ps
`default_nettype none
interface gsrr_in_if;
    logic             valid;
    logic             ready;
    gsrr_pkg::t_symbol symbol;
    logic             last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface
`default_nettype wire

// File: src/gsrr_out_if.sv
// Interface of the result channel.
`timescale 1ns / 1ps
`default_nettype none
interface gsrr_out_if;
    logic                              valid;
    logic                              ready;
    gsrr_pkg::t_status                 status;
    logic [gsrr_pkg::DEPTH_W-1:0]      depth;
    gsrr_pkg::t_symbol                 top_symbol;
    logic [gsrr_pkg::COUNT_W-1:0]      reduce_count;

    modport source (output valid, output status, output depth, output top_symbol,
                    output reduce_count, input ready);
    modport sink   (input valid, input status, input depth, input top_symbol,
                    input reduce_count, output ready);
endinterface
`default_nettype wire

// File: src/gsrr_cfg_if.sv
// Interface of the rule register write channel.
`timescale 1ns / 1ps
`default_nettype none
interface gsrr_cfg_if;
    logic                 valid;
    logic                 ready;
    gsrr_pkg::t_cfg_index index;
    gsrr_pkg::t_rule      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/greedy_shift_reduce_recognizer_core.sv
// Top level of the greedy shift-reduce recogniser with its rule match sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Each request on the input channel pushes one symbol on the stack, after which parallel
// rule comparators check all rules against the top of the stack once per cycle and apply
// at most one reduction per cycle (longest right side first, lowest rule among equals).
// Ordinary items pass the reduction state, then the done state; items discarded after an
// error or meeting a full stack are not pushed and go straight to the done state. The
// input is not ready while an item is being worked on, but it is ready again while the
// previous result still waits in the output register. Rule registers may only be written
// while the block is idle; writes to an index at or above NUM_RULES are ignored.
module greedy_shift_reduce_recognizer_core #(
    parameter int STACK_DEPTH = gsrr_pkg::STACK_DEPTH_DEF,
    parameter int NUM_RULES   = gsrr_pkg::NUM_RULES_DEF,
    parameter int MAX_RHS     = gsrr_pkg::MAX_RHS_DEF,
    parameter int MAX_REDUCE  = gsrr_pkg::MAX_REDUCE_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gsrr_in_if.sink      i_in,
    gsrr_out_if.source   o_out,
    gsrr_cfg_if.sink     i_cfg
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(MAX_REDUCE + 1);
    localparam int LW = $clog2(MAX_RHS + 1);
    localparam int RW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    gsrr_pkg::t_state  r_state, n_state;
    gsrr_pkg::t_symbol r_stack [STACK_DEPTH];
    gsrr_pkg::t_symbol n_stack [STACK_DEPTH];
    logic [DW-1:0]     r_depth, n_depth;
    logic [CW-1:0]     r_count, n_count;
    gsrr_pkg::t_status r_status, n_status;
    logic              r_last, n_last;
    logic              r_skip, n_skip;
    logic              r_err_seen, n_err_seen;
    gsrr_pkg::t_rule   r_rule [NUM_RULES];

    logic                         r_out_valid;
    gsrr_pkg::t_status            r_out_status;
    logic [gsrr_pkg::DEPTH_W-1:0] r_out_depth;
    gsrr_pkg::t_symbol            r_out_top;
    logic [gsrr_pkg::COUNT_W-1:0] r_out_count;

    logic in_fire;
    logic out_load;
    logic stack_full;
    logic at_limit;

    logic [NUM_RULES-1:0] rule_hit;
    logic [LW-1:0]        rule_len [NUM_RULES];
    logic                 hit;
    logic [LW-1:0]        best_len;
    gsrr_pkg::t_symbol    best_lhs;

    gsrr_pkg::t_status            res_status;
    logic [gsrr_pkg::DEPTH_W-1:0] res_depth;
    gsrr_pkg::t_symbol            res_top;
    logic [gsrr_pkg::COUNT_W-1:0] res_count;

    assign i_in.ready  = (r_state == gsrr_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_load    = (r_state == gsrr_pkg::S_DONE) && (!r_out_valid || o_out.ready);
    assign stack_full  = (r_depth >= DW'(STACK_DEPTH));
    assign at_limit    = (r_count == CW'(MAX_REDUCE));

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.depth        = r_out_depth;
    assign o_out.top_symbol   = r_out_top;
    assign o_out.reduce_count = r_out_count;

    // Match of every rule against the top of the stack; entry 0 is the top.
    always_comb begin
        logic          lm;
        logic [AW-1:0] idx;
        for (int m = 0; m < NUM_RULES; m++) begin
            rule_hit[m] = 1'b0;
            rule_len[m] = '0;
            for (int l = 1; l <= MAX_RHS; l++) begin
                lm = 1'b1;
                for (int i = 0; i < l; i++) begin
                    idx = AW'(gsrr_pkg::clamp_idx(l - 1 - i, STACK_DEPTH - 1));
                    if (r_rule[m][gsrr_pkg::RHS_LSB + gsrr_pkg::SYM_W*i +: gsrr_pkg::SYM_W]
                        != r_stack[idx]) begin
                        lm = 1'b0;
                    end
                end
                if ((r_rule[m][15:8] == 8'(l)) && lm && (int'(r_depth) >= l)) begin
                    rule_hit[m] = 1'b1;
                    rule_len[m] = LW'(l);
                end
            end
        end
    end

    always_comb begin
        hit      = 1'b0;
        best_len = '0;
        best_lhs = '0;
        for (int m = 0; m < NUM_RULES; m++) begin
            if (rule_hit[m] && (!hit || (rule_len[m] > best_len))) begin
                hit      = 1'b1;
                best_len = rule_len[m];
                best_lhs = r_rule[m][7:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gsrr_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (r_err_seen || stack_full) begin
                        n_state = gsrr_pkg::S_DONE;
                    end else begin
                        n_state = gsrr_pkg::S_REDUCE;
                    end
                end
            end
            gsrr_pkg::S_REDUCE: begin
                if (!hit || at_limit) begin
                    n_state = gsrr_pkg::S_DONE;
                end
            end
            gsrr_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = gsrr_pkg::S_IDLE;
                end
            end
            default: n_state = gsrr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        logic [AW-1:0] src;
        src        = '0;
        n_stack    = r_stack;
        n_depth    = r_depth;
        n_count    = r_count;
        n_status   = r_status;
        n_last     = r_last;
        n_skip     = r_skip;
        n_err_seen = r_err_seen;
        unique case (r_state)
            gsrr_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_last   = i_in.last;
                    n_count  = '0;
                    n_status = gsrr_pkg::ST_RUNNING;
                    n_skip   = r_err_seen;
                    if (!r_err_seen) begin
                        if (stack_full) begin
                            n_status = gsrr_pkg::ST_OVERFLOW;
                        end else begin
                            n_stack[0] = i_in.symbol;
                            for (int k = 1; k < STACK_DEPTH; k++) begin
                                n_stack[k] = r_stack[k-1];
                            end
                            n_depth = r_depth + DW'(1);
                        end
                    end
                end
            end
            gsrr_pkg::S_REDUCE: begin
                if (hit) begin
                    if (at_limit) begin
                        n_status = gsrr_pkg::ST_LIMIT;
                    end else begin
                        n_stack[0] = best_lhs;
                        for (int k = 1; k < STACK_DEPTH; k++) begin
                            for (int s = 0; s < MAX_RHS; s++) begin
                                if (int'(best_len) - 1 == s) begin
                                    src        = AW'(gsrr_pkg::clamp_idx(k + s,
                                                                         STACK_DEPTH - 1));
                                    n_stack[k] = r_stack[src];
                                end
                            end
                        end
                        n_depth = r_depth - DW'(best_len) + DW'(1);
                        n_count = r_count + CW'(1);
                    end
                end
            end
            gsrr_pkg::S_DONE: begin
                if (out_load) begin
                    if (r_skip) begin
                        if (r_last) begin
                            n_err_seen = 1'b0;
                        end
                    end else if (r_status != gsrr_pkg::ST_RUNNING) begin
                        n_depth    = '0;
                        n_err_seen = !r_last;
                    end else if (r_last) begin
                        n_depth = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_status = gsrr_pkg::ST_RUNNING;
        res_depth  = gsrr_pkg::DEPTH_W'(r_depth);
        res_top    = (r_depth == '0) ? '0 : r_stack[0];
        res_count  = gsrr_pkg::COUNT_W'(r_count);
        if (r_skip) begin
            res_status = r_last ? gsrr_pkg::ST_REJECT : gsrr_pkg::ST_RUNNING;
            res_depth  = '0;
            res_top    = '0;
            res_count  = '0;
        end else if (r_status != gsrr_pkg::ST_RUNNING) begin
            res_status = r_status;
        end else if (r_last) begin
            res_status = (r_depth == DW'(1)) ? gsrr_pkg::ST_ACCEPT : gsrr_pkg::ST_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gsrr_pkg::S_IDLE;
            r_depth     <= '0;
            r_count     <= '0;
            r_status    <= gsrr_pkg::ST_RUNNING;
            r_last      <= 1'b0;
            r_skip      <= 1'b0;
            r_err_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_count     <= n_count;
            r_status    <= n_status;
            r_last      <= n_last;
            r_skip      <= n_skip;
            r_err_seen  <= n_err_seen;
            r_out_valid <= out_load || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_stack <= n_stack;
        if (out_load) begin
            r_out_status <= res_status;
            r_out_depth  <= res_depth;
            r_out_top    <= res_top;
            r_out_count  <= res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_RULES; m++) begin
                r_rule[m] <= '0;
            end
        end else if (i_cfg.valid && i_cfg.ready && (int'(i_cfg.index) < NUM_RULES)) begin
            r_rule[i_cfg.index[RW-1:0]] <= i_cfg.data;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond its capacity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REDUCE))
        else $error("reduction count beyond its limit");

    a_reduce_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsrr_pkg::S_REDUCE) && hit && !at_limit |=> r_depth <= $past(r_depth))
        else $error("a reduction made the stack deeper");

    a_accept_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && (res_status == gsrr_pkg::ST_ACCEPT) |-> r_depth == DW'(1) && !r_skip)
        else $error("accept reported without exactly one symbol");

    a_no_skip_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsrr_pkg::S_REDUCE) |-> !r_skip && (r_status != gsrr_pkg::ST_OVERFLOW))
        else $error("reduction pass on a discarded or overflowing item");

endmodule
`default_nettype wire

// File: sim/gsrr_parse_checker.sv
// Watches the recogniser's channels, predicts every result from its own copy of the parser and compares.
`timescale 1ns / 1ps
module gsrr_parse_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    gsrr_in_if   i_in,
    gsrr_out_if  i_out,
    gsrr_cfg_if  i_cfg,
    output int   o_pending,
    output int   o_fail_count
);
    import gsrr_pkg::*;

    localparam int STACK_N   = STACK_DEPTH_DEF;
    localparam int RULES_N   = NUM_RULES_DEF;
    localparam int RHS_MAX   = MAX_RHS_DEF;
    localparam int REDUCE_N  = MAX_REDUCE_DEF;
    localparam int REG_AW    = $clog2(NUM_REGS);

    typedef struct packed {
        t_status              status;
        logic [DEPTH_W-1:0]   depth;
        t_symbol              top_symbol;
        logic [COUNT_W-1:0]   reduce_count;
    } t_parse_result;

    t_rule         productions [NUM_REGS];
    t_symbol       parse_stack [STACK_N];
    int            stack_fill;
    logic          string_poisoned;
    t_parse_result parse_results_due [$];
    int            fails;

    function automatic bit suffix_matches(t_rule r, int n);
        int rl;
        rl = int'(r[15:8]);
        if (rl == 0 || rl > RHS_MAX || rl != n || n > stack_fill) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (parse_stack[stack_fill - n + i] != r[RHS_LSB + 8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit find_reduction(output t_symbol lhs, output int n);
        int len;
        len = (stack_fill > RHS_MAX) ? RHS_MAX : stack_fill;
        lhs = '0;
        n   = 0;
        while (len >= 1) begin
            for (int m = 0; m < RULES_N; m++) begin
                if (suffix_matches(productions[m], len)) begin
                    lhs = productions[m][7:0];
                    n   = len;
                    return 1'b1;
                end
            end
            len--;
        end
        return 1'b0;
    endfunction

    function automatic t_parse_result predict_parse(t_symbol sym, logic is_last);
        t_parse_result res;
        t_symbol       lhs;
        int            n;
        int            reductions;
        res        = '0;
        res.status = ST_RUNNING;
        reductions = 0;
        if (string_poisoned) begin
            if (is_last) begin
                res.status      = ST_REJECT;
                string_poisoned = 1'b0;
            end
            return res;
        end
        if (stack_fill >= STACK_N) begin
            res.status = ST_OVERFLOW;
        end else begin
            parse_stack[stack_fill] = sym;
            stack_fill++;
            while (find_reduction(lhs, n)) begin
                if (reductions >= REDUCE_N) begin
                    res.status = ST_LIMIT;
                    break;
                end
                stack_fill -= n;
                parse_stack[stack_fill] = lhs;
                stack_fill++;
                reductions++;
            end
        end
        res.depth        = DEPTH_W'(stack_fill);
        res.top_symbol   = (stack_fill != 0) ? parse_stack[stack_fill - 1] : '0;
        res.reduce_count = COUNT_W'(reductions);
        if (res.status != ST_RUNNING) begin
            stack_fill = 0;
            if (!is_last) string_poisoned = 1'b1;
        end else if (is_last) begin
            res.status = (stack_fill == 1) ? ST_ACCEPT : ST_REJECT;
            stack_fill = 0;
        end
        return res;
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_parse_result want;
        if (!i_rst_n) begin
            foreach (productions[k]) productions[k] = '0;
            stack_fill      = 0;
            string_poisoned = 1'b0;
            parse_results_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready && int'(i_cfg.index) < RULES_N) begin
                productions[i_cfg.index[REG_AW-1:0]] = i_cfg.data;
            end
            if (i_out.valid && i_out.ready) begin
                if (parse_results_due.size() == 0) begin
                    $error("result with status %0d arrived with no request outstanding",
                           i_out.status);
                    fails++;
                end else begin
                    want = parse_results_due.pop_front();
                    check_field("status", int'(want.status), int'(i_out.status));
                    check_field("depth", int'(want.depth), int'(i_out.depth));
                    check_field("top_symbol", int'(want.top_symbol), int'(i_out.top_symbol));
                    check_field("reduce_count", int'(want.reduce_count),
                                int'(i_out.reduce_count));
                end
            end
            if (i_in.valid && i_in.ready) begin
                parse_results_due.push_back(predict_parse(i_in.symbol, i_in.last));
            end
        end
        o_pending    <= parse_results_due.size();
        o_fail_count <= fails;
    end

endmodule

// File: sim/greedy_shift_reduce_recognizer_core_tb.sv
// Testbench top: drives symbol strings and rule sets into the recogniser and gives the verdict.
`timescale 1ns / 1ps
module greedy_shift_reduce_recognizer_core_tb;
    import gsrr_pkg::*;

    localparam int      QUIET_LIMIT  = 2000;
    localparam int      HOLD_CYCLES  = 300;
    localparam int      TAIL_CYCLES  = MAX_REDUCE_DEF + 8;
    localparam int      PHASES       = 9;
    localparam int      PHASE_ITEMS  = 200;
    localparam t_symbol SYM_OPEN     = 8'h28;
    localparam t_symbol SYM_CLOSE    = 8'h29;
    localparam t_symbol SYM_A        = 8'h61;
    localparam t_symbol SYM_S        = 8'h53;
    localparam t_symbol SYM_X        = 8'h58;

    typedef enum {GK_PAREN, GK_RANDOM, GK_EMPTY} t_grammar_kind;

    logic i_clk;
    logic i_rst_n;

    gsrr_in_if  in_ch ();
    gsrr_out_if out_ch ();
    gsrr_cfg_if cfg_ch ();

    int      pending_results;
    int      failure_total;
    int      quiet_cycles;
    int      symbols_sent;
    bit      src_idle;
    bit      snk_idle;
    bit      hold_request;
    t_rule   grammar_regs [NUM_REGS];
    t_symbol alphabet [4];
    t_symbol word_q [$];

    greedy_shift_reduce_recognizer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    gsrr_parse_checker u_parse_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending_results),
        .o_fail_count (failure_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap(bit enabled);
        return enabled ? $urandom_range(0, 17) : 0;
    endfunction

    function automatic t_rule make_rule(t_symbol lhs, int len, t_symbol rhs [MAX_RHS_DEF]);
        t_rule r;
        r        = {$urandom, $urandom};
        r[7:0]   = lhs;
        r[15:8]  = len[7:0];
        for (int i = 0; i < MAX_RHS_DEF && i < len; i++) r[RHS_LSB + 8*i +: 8] = rhs[i];
        return r;
    endfunction

    task automatic send_symbol(input t_symbol sym, input logic mark_last);
        int gap;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.symbol <= sym;
        in_ch.last   <= mark_last;
        do @(posedge i_clk); while (!in_ch.ready);
        symbols_sent++;
    endtask

    task automatic send_word(input bit terminate);
        foreach (word_q[i]) send_symbol(word_q[i], terminate && i == word_q.size() - 1);
    endtask

    task automatic send_text(input string txt);
        word_q.delete();
        for (int i = 0; i < txt.len(); i++) word_q.push_back(t_symbol'(txt[i]));
        send_word(1'b1);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic load_grammar();
        drain_results();
        for (int k = 0; k < NUM_REGS; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_cfg_index'(k);
            cfg_ch.data  <= grammar_regs[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        // An index beyond the rule set must leave every production untouched.
        cfg_ch.index <= t_cfg_index'(NUM_REGS + $urandom_range(0, 7));
        cfg_ch.data  <= {$urandom, $urandom};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_paren_grammar();
        grammar_regs[0] = make_rule(SYM_S, 3, '{SYM_OPEN, SYM_S, SYM_CLOSE, 0, 0, 0});
        grammar_regs[1] = make_rule(SYM_S, 1, '{SYM_A, 0, 0, 0, 0, 0});
        grammar_regs[2] = make_rule(SYM_S, 2, '{SYM_S, SYM_S, 0, 0, 0, 0});
        grammar_regs[3] = make_rule(SYM_S, 2, '{SYM_OPEN, SYM_CLOSE, 0, 0, 0, 0});
        grammar_regs[4] = make_rule(SYM_X, 3, '{SYM_OPEN, SYM_S, SYM_CLOSE, 0, 0, 0});
        grammar_regs[5] = make_rule(SYM_X, 1, '{SYM_CLOSE, 0, 0, 0, 0, 0});
        grammar_regs[6] = make_rule(SYM_S, MAX_RHS_DEF + 1, '{SYM_A, SYM_A, SYM_A, 0, 0, 0});
        grammar_regs[7] = '1;
    endtask

    task automatic set_random_grammar();
        int      pick;
        int      len;
        t_symbol rhs [MAX_RHS_DEF];
        alphabet = '{8'h00, 8'hFF, t_symbol'($urandom), t_symbol'($urandom)};
        for (int k = 0; k < NUM_REGS; k++) begin
            pick = $urandom_range(0, 15);
            if (pick < 6)       len = 1;
            else if (pick < 10) len = 2;
            else if (pick < 12) len = 3;
            else if (pick == 12) len = $urandom_range(4, MAX_RHS_DEF);
            else if (pick == 13) len = 0;
            else if (pick == 14) len = MAX_RHS_DEF + 1;
            else                len = 255;
            foreach (rhs[i]) rhs[i] = alphabet[$urandom_range(0, 3)];
            grammar_regs[k] = make_rule(alphabet[$urandom_range(0, 3)], len, rhs);
        end
    endtask

    task automatic build_balanced();
        int nest;
        int pick;
        word_q.delete();
        nest = 0;
        if ($urandom_range(0, 9) == 0) begin
            nest = $urandom_range(6, 10);
            repeat (nest) word_q.push_back(SYM_OPEN);
            word_q.push_back(SYM_A);
        end else begin
            repeat ($urandom_range(1, 10)) begin
                pick = $urandom_range(0, 2);
                if (pick == 0 && nest < 4) begin
                    word_q.push_back(SYM_OPEN);
                    nest++;
                end else if (pick == 1 && nest > 0) begin
                    word_q.push_back(SYM_CLOSE);
                    nest--;
                end else begin
                    word_q.push_back(SYM_A);
                end
            end
        end
        repeat (nest) word_q.push_back(SYM_CLOSE);
    endtask

    task automatic build_noise(input t_grammar_kind kind);
        int pick;
        word_q.delete();
        repeat ($urandom_range(1, 12)) begin
            pick = $urandom_range(0, 4);
            if (kind == GK_RANDOM)  word_q.push_back(alphabet[$urandom_range(0, 3)]);
            else if (kind == GK_EMPTY || pick == 4) word_q.push_back(t_symbol'($urandom));
            else if (pick == 0)     word_q.push_back(SYM_OPEN);
            else if (pick == 1)     word_q.push_back(SYM_CLOSE);
            else if (pick == 2)     word_q.push_back(SYM_A);
            else                    word_q.push_back(SYM_S);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int gap;
        bit hold_done;
        hold_done    = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(snk_idle);
            if (hold_request && !hold_done) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        t_grammar_kind kind;
        int            quota;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.symbol  <= '0;
        in_ch.last    <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= '0;
        cfg_ch.data   <= '0;
        symbols_sent  = 0;
        src_idle      = 1'b1;
        snk_idle      = 1'b1;
        hold_request  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_paren_grammar();
        load_grammar();
        send_text("a");
        send_text("(a)");
        send_text("()");
        send_text("((");
        send_text(")");
        // Nine opening brackets overflow the stack; the rest of the string is thrown away.
        send_text("((((((((()a");
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);

        // A production that rewrites a symbol into itself runs into the reduction limit.
        foreach (grammar_regs[k]) grammar_regs[k] = '0;
        grammar_regs[0] = make_rule(SYM_X, 1, '{SYM_X, 0, 0, 0, 0, 0});
        load_grammar();
        send_text("X");
        send_text("Xa");

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 3) begin
                kind = GK_EMPTY;
                foreach (grammar_regs[k]) grammar_regs[k] = k[0] ? '1 : '0;
            end else if (phase % 2 == 0) begin
                kind = GK_PAREN;
                set_paren_grammar();
            end else begin
                kind = GK_RANDOM;
                set_random_grammar();
            end
            load_grammar();
            if (phase == 4) hold_request = 1'b1;
            quota = symbols_sent + PHASE_ITEMS;
            while (symbols_sent < quota) begin
                if ($urandom_range(0, 15) == 0) begin
                    src_idle = ($urandom_range(0, 3) != 0);
                    snk_idle = ($urandom_range(0, 3) != 0);
                end
                if (kind == GK_PAREN && $urandom_range(0, 15) < 13) begin
                    build_balanced();
                    send_word(1'b1);
                end else begin
                    build_noise(kind);
                    send_word($urandom_range(0, 9) != 0);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failure_total == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
